>>> sv/mto_pkg.sv
// Shared constants, register codes and types of the multi-tone oscillator.
package mto_pkg;

  // Defaults of the top-level parameters
  localparam int DEF_MAX_TONES  = 4;
  localparam int DEF_SINE_DEPTH = 1024;
  localparam int DEF_PHASE_W    = 32;

  // Configuration port
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 49;
  localparam int NUM_TONE_REGS = 4;

  // Tone register layout
  localparam int TONE_W     = 49;
  localparam int AMP_LSB    = 32;
  localparam int AMP_W      = 16;
  localparam int SQUARE_BIT = 48;

  localparam int ACTIVE_W = 3;
  localparam int GAIN_W   = 16;
  localparam int LEVEL_W  = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  // Noise source
  localparam int LFSR_W = 32;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'd1;
  localparam int NOISE_CENTER_SH = 15;

  // Sine table, signed Q16 half-amplitude
  localparam int SINE_W = 17;
  localparam logic signed [SINE_W-1:0] HALF_POS = 17'sd32768;
  localparam logic signed [SINE_W-1:0] HALF_NEG = -17'sd32768;

  localparam longint Q28_ONE     = 64'sd268435456;
  localparam longint Q28_PI      = 64'sd843314857;
  localparam longint Q28_HALF_PI = 64'sd421657428;
  localparam longint Q28_TWO_PI  = 64'sd1686629713;
  localparam int     Q28_SH      = 28;
  localparam int     Q28_TO_Q16_SH = 13;
  localparam int     TAYLOR_TERMS = 5;
  localparam longint TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110};

  // Output scaling
  localparam int SAMPLE_W   = 24;
  localparam int SHIFT_OUT  = 21;
  localparam int RND_HALF   = 1 << (SHIFT_OUT - 1);
  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  // Job queue between front and back
  localparam int JOB_FIFO_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_0,
    REG_TONE_1,
    REG_TONE_2,
    REG_TONE_3,
    REG_ACTIVE,
    REG_GAIN,
    REG_NOISE
  } cfg_reg_t;

  typedef struct packed {
    logic [ACTIVE_W-1:0] active_tones;
    logic [GAIN_W-1:0]   output_gain;
    logic [LEVEL_W-1:0]  noise_level;
  } osc_cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_MUL,
    BK_NOISE,
    BK_SUM,
    BK_GAIN,
    BK_OUT
  } bk_state_t;

endpackage

>>> sv/mto_job_fifo.sv
// Short job queue between the tick front end and the synthesis back end.
module mto_job_fifo
  import mto_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = JOB_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> sv/mto_front.sv
// Front end: takes ticks, advances phase accumulators and, with noise on, the noise LFSR; queues jobs.
module mto_front
  import mto_pkg::*;
#(
  parameter int MAX_TONES        = DEF_MAX_TONES,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH,
  parameter int PHASE_WIDTH      = DEF_PHASE_W,
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH),
  localparam int JOB_W = LFSR_W + MAX_TONES * IDX_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic                             in_tick,
  input  logic                             job_full,
  input  logic [MAX_TONES-1:0][TONE_W-1:0] tone_cfg,
  input  logic                             noise_on,
  output logic                             job_push,
  output logic [JOB_W-1:0]                 job_data
);

  localparam int SCALE_W = PHASE_WIDTH + IDX_W;

  logic [MAX_TONES-1:0][PHASE_WIDTH-1:0] phase_r, phase_nxt;
  logic [MAX_TONES-1:0][SCALE_W-1:0]     scaled;
  logic [MAX_TONES-1:0][IDX_W-1:0]       idx;
  logic [LFSR_W-1:0]                     lfsr_r, lfsr_nxt, lfsr_out;
  logic                                  take;

  // Accepted beats with tick low are dropped here
  assign take = in_push && !job_full && in_tick;

  always_comb begin
    for (int t = 0; t < MAX_TONES; t++) begin
      phase_nxt[t] = phase_r[t] + tone_cfg[t][PHASE_WIDTH-1:0];
      scaled[t]    = SCALE_W'(phase_nxt[t]) * SCALE_W'(SINE_TABLE_DEPTH);
      idx[t]       = scaled[t][SCALE_W-1:PHASE_WIDTH];
    end
    lfsr_nxt = lfsr_r >> 1;
    if (lfsr_r[0]) begin
      lfsr_nxt = lfsr_nxt ^ LFSR_TAPS;
    end
    lfsr_out = noise_on ? lfsr_nxt : lfsr_r;
  end

  assign job_push = take;
  assign job_data = {lfsr_out, idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      lfsr_r  <= LFSR_SEED;
    end else if (take) begin
      phase_r <= phase_nxt;
      lfsr_r  <= lfsr_out;
    end
  end

endmodule

>>> sv/mto_back.sv
// Back end: sine ROM, shared multiplier and accumulator; rounds, saturates, holds the result.
module mto_back
  import mto_pkg::*;
#(
  parameter int MAX_TONES        = DEF_MAX_TONES,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH,
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH),
  localparam int JOB_W = LFSR_W + MAX_TONES * IDX_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  osc_cfg_t                         cfg,
  input  logic [MAX_TONES-1:0][TONE_W-1:0] tone_cfg,
  input  logic                             job_valid,
  input  logic [JOB_W-1:0]                 job_data,
  output logic                             job_pop,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [SAMPLE_W-1:0]              out_sample
);

  localparam int TIDX_W  = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int TCNT_W  = $clog2(MAX_TONES + 1);
  localparam int ACT_X_W = (ACTIVE_W + 1 > TCNT_W) ? ACTIVE_W + 1 : TCNT_W;
  localparam int SUM_W   = 32 + $clog2(MAX_TONES + 1);
  localparam int MULB_W  = AMP_W + 1;
  localparam int PROD_W  = SUM_W + MULB_W;

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  // Half-amplitude sine, Q16, from a Q28 Taylor series on the first quadrant
  function automatic sine_rom_t build_sine();
    sine_rom_t tab;
    longint    theta;
    longint    x2;
    longint    term;
    longint    acc;
    logic      neg;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      theta = (longint'(i) * Q28_TWO_PI) / SINE_TABLE_DEPTH;
      neg   = 1'b0;
      if (theta > Q28_PI) begin
        theta = theta - Q28_PI;
        neg   = 1'b1;
      end
      if (theta > Q28_HALF_PI) theta = Q28_PI - theta;
      if (theta < 0) theta = 0;
      x2   = (theta * theta) >>> Q28_SH;
      term = theta;
      acc  = theta;
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
        term = ((term * x2) >>> Q28_SH) / TAYLOR_DIV[k];
        if ((k & 1) == 0) acc = acc - term;
        else acc = acc + term;
      end
      if (acc < 0) acc = 0;
      if (acc > Q28_ONE) acc = Q28_ONE;
      acc    = (acc + (longint'(1) <<< (Q28_TO_Q16_SH - 1))) >>> Q28_TO_Q16_SH;
      tab[i] = neg ? -SINE_W'(acc) : SINE_W'(acc);
    end
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  bk_state_t state_r, state_nxt;

  logic [MAX_TONES-1:0][IDX_W-1:0] job_idx_r, job_idx_nxt, job_idx_in;
  logic [LFSR_W-1:0]               job_lfsr_r, job_lfsr_nxt;
  logic [TIDX_W-1:0]               tone_r, tone_nxt;
  logic signed [SUM_W-1:0]         acc_r, acc_nxt, add_term, noise_term;
  logic [SUM_W-1:0]                noise_hi, noise_mid;
  logic signed [PROD_W-1:0]        prod_r, prod_nxt, mul_p;
  logic signed [SUM_W-1:0]         mul_a;
  logic signed [MULB_W-1:0]        mul_b;
  logic                            add_pend_r, add_pend_nxt;
  logic                            add_noise_r, add_noise_nxt;
  logic signed [SINE_W-1:0]        rom_q_r, tone_v;
  logic [IDX_W-1:0]                rom_addr;
  logic [TONE_W-1:0]               tone_word;
  logic [ACT_X_W-1:0]              act_ext, act_clip;
  logic [TCNT_W-1:0]               tone_cnt;
  logic                            tone_last, noise_on;
  logic signed [PROD_W-1:0]        rnd_sum, rnd_q;
  logic [SAMPLE_W-1:0]             sample_sat;
  logic                            out_vld_r, out_vld_nxt;
  logic [SAMPLE_W-1:0]             out_sample_r, out_sample_nxt;

  assign job_idx_in = job_data[MAX_TONES*IDX_W-1:0];

  // Tone count, clipped to the number of tone units
  assign act_ext   = ACT_X_W'(cfg.active_tones);
  assign act_clip  = (act_ext > ACT_X_W'(MAX_TONES)) ? ACT_X_W'(MAX_TONES) : act_ext;
  assign tone_cnt  = TCNT_W'(act_clip);
  assign tone_last = (TCNT_W'(tone_r) + TCNT_W'(1)) == tone_cnt;
  assign noise_on  = (cfg.noise_level != '0);

  assign rom_addr  = job_idx_r[tone_r];
  assign tone_word = tone_cfg[tone_r];

  // Square mode follows the sign of the table entry; zero counts as positive
  assign tone_v = tone_word[SQUARE_BIT] ? (rom_q_r[SINE_W-1] ? HALF_NEG : HALF_POS) : rom_q_r;

  // Noise term: (r * N) >> 16, recentered by N << 15
  assign noise_hi   = SUM_W'(prod_r[LFSR_W+LEVEL_W-1:LEVEL_W]);
  assign noise_mid  = SUM_W'(cfg.noise_level) << NOISE_CENTER_SH;
  assign noise_term = $signed(noise_hi - noise_mid);
  assign add_term   = add_noise_r ? noise_term : prod_r[SUM_W-1:0];

  assign mul_p = mul_a * mul_b;

  // Round half away from zero, then clamp to the sample range
  always_comb begin
    rnd_sum = prod_r + (prod_r[PROD_W-1] ? PROD_W'(RND_HALF - 1) : PROD_W'(RND_HALF));
    rnd_q   = rnd_sum >>> SHIFT_OUT;
    if (rnd_q > PROD_W'(SAMPLE_MAX)) begin
      sample_sat = SAMPLE_W'(SAMPLE_MAX);
    end else if (rnd_q < PROD_W'(SAMPLE_MIN)) begin
      sample_sat = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sample_sat = rnd_q[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    job_idx_nxt    = job_idx_r;
    job_lfsr_nxt   = job_lfsr_r;
    tone_nxt       = tone_r;
    prod_nxt       = prod_r;
    add_pend_nxt   = 1'b0;
    add_noise_nxt  = 1'b0;
    acc_nxt        = add_pend_r ? acc_r + add_term : acc_r;
    out_vld_nxt    = out_vld_r && !out_pop;
    out_sample_nxt = out_sample_r;
    job_pop        = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop      = 1'b1;
          job_idx_nxt  = job_idx_in;
          job_lfsr_nxt = job_data[JOB_W-1 -: LFSR_W];
          tone_nxt     = '0;
          acc_nxt      = '0;
          state_nxt    = (tone_cnt != '0) ? BK_READ : BK_NOISE;
        end
      end
      BK_READ: begin
        state_nxt = BK_MUL;
      end
      BK_MUL: begin
        mul_a        = SUM_W'(tone_v);
        mul_b        = $signed({1'b0, tone_word[AMP_LSB +: AMP_W]});
        prod_nxt     = mul_p;
        add_pend_nxt = 1'b1;
        tone_nxt     = tone_r + TIDX_W'(1);
        state_nxt    = tone_last ? BK_NOISE : BK_READ;
      end
      BK_NOISE: begin
        if (noise_on) begin
          mul_a         = SUM_W'(job_lfsr_r);
          mul_b         = $signed({1'b0, cfg.noise_level});
          prod_nxt      = mul_p;
          add_pend_nxt  = 1'b1;
          add_noise_nxt = 1'b1;
        end
        state_nxt = BK_SUM;
      end
      BK_SUM: begin
        state_nxt = BK_GAIN;
      end
      BK_GAIN: begin
        mul_a     = acc_r;
        mul_b     = $signed({1'b0, cfg.output_gain});
        prod_nxt  = mul_p;
        state_nxt = BK_OUT;
      end
      BK_OUT: begin
        // hold until the result register frees up
        if (!out_vld_r || out_pop) begin
          out_vld_nxt    = 1'b1;
          out_sample_nxt = sample_sat;
          state_nxt      = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      add_pend_r  <= 1'b0;
      add_noise_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      add_pend_r  <= add_pend_nxt;
      add_noise_r <= add_noise_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_idx_r    <= job_idx_nxt;
    job_lfsr_r   <= job_lfsr_nxt;
    tone_r       <= tone_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // Sine ROM, registered read
  always_ff @(posedge clk) begin
    rom_q_r <= SINE_ROM[rom_addr];
  end

  assign out_empty  = !out_vld_r;
  assign out_sample = out_sample_r;

endmodule

>>> sv/multi_tone_oscillator_top.sv
// Multi-tone oscillator top level: configuration registers, front end, job queue, back end.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_push / in_full       | in_tick
//  out     | output    | out_empty / out_pop     | out_sample (signed Q0.23)
//  cfg     | input     | cfg_we (always taken)   | cfg_index, cfg_wdata
//
// In the back end each tone, up to the clipped active tone count, costs one sine ROM read
// and one pass through the single shared multiplier; then noise, gain and rounding follow.
// Synchronous reset sets registers to defaults, phases to 0 and the LFSR to 1.
// The job queue holds two ticks; the result register holds until popped.
module multi_tone_oscillator_top
  import mto_pkg::*;
#(
  parameter int MAX_TONES        = DEF_MAX_TONES,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH,
  parameter int PHASE_WIDTH      = DEF_PHASE_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_tick,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [SAMPLE_W-1:0]   out_sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int JOB_W = LFSR_W + MAX_TONES * IDX_W;

  logic [MAX_TONES-1:0][TONE_W-1:0] tone_cfg;
  osc_cfg_t                         cfg_r, cfg_nxt;
  logic                             job_push, job_pop, job_full, job_valid;
  logic [JOB_W-1:0]                 job_data, job_head;

  // Tone registers; tones beyond the register file stay at zero
  for (genvar g = 0; g < MAX_TONES; g++) begin : g_tone
    if (g < NUM_TONE_REGS) begin : g_reg
      logic [TONE_W-1:0] tone_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tone_r <= '0;
        end else if (cfg_we && (cfg_index == CFG_IDX_W'(REG_TONE_0) + CFG_IDX_W'(g))) begin
          tone_r <= cfg_wdata[TONE_W-1:0];
        end
      end
      assign tone_cfg[g] = tone_r;
    end else begin : g_zero
      assign tone_cfg[g] = '0;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ACTIVE: cfg_nxt.active_tones = cfg_wdata[ACTIVE_W-1:0];
        REG_GAIN:   cfg_nxt.output_gain  = cfg_wdata[GAIN_W-1:0];
        REG_NOISE:  cfg_nxt.noise_level  = cfg_wdata[LEVEL_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_tones <= '0;
      cfg_r.output_gain  <= GAIN_RESET;
      cfg_r.noise_level  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mto_front #(
    .MAX_TONES        (MAX_TONES),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_WIDTH      (PHASE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_tick  (in_tick),
    .job_full (job_full),
    .tone_cfg (tone_cfg),
    .noise_on (cfg_r.noise_level != '0),
    .job_push (job_push),
    .job_data (job_data)
  );

  mto_job_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_FIFO_DEPTH)
  ) u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_data),
    .full    (job_full),
    .pop     (job_pop),
    .valid   (job_valid),
    .rd_data (job_head)
  );

  mto_back #(
    .MAX_TONES        (MAX_TONES),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .tone_cfg   (tone_cfg),
    .job_valid  (job_valid),
    .job_data   (job_head),
    .job_pop    (job_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_sample (out_sample)
  );

  assign in_full = job_full;

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("back end popped an empty job queue");

  a_no_job_without_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_tick) |-> !job_push)
    else $error("job queued for a beat with tick low");

  a_job_fits: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  a_lfsr_alive: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (job_data[JOB_W-1 -: LFSR_W] != '0))
    else $error("noise LFSR reached the all-zero state");

endmodule
